// ----- design/nptr_pkg.sv -----
// ----------------------------------------------------------------------------
// nptr_pkg
// Shared types and constants of the numeric token prefix recognizer.
// ----------------------------------------------------------------------------
package nptr_pkg;

    typedef enum logic [3:0] {
        PH_START,
        PH_ISIGN,
        PH_IZERO,
        PH_IPFX,
        PH_IDIG,
        PH_FSIGN,
        PH_FDEC,
        PH_FZERO,
        PH_FHEX,
        PH_FINF,
        PH_FNAN,
        PH_FNSEQ,
        PH_FNEND
    } phase_t;

    // number flag bit positions
    localparam int FL_DIG  = 0;
    localparam int FL_DOT  = 1;
    localparam int FL_EXP  = 2;
    localparam int FL_ESGN = 3;
    localparam int FL_EDIG = 4;

    // configuration register indexes
    localparam logic [1:0] REG_FLOAT_MODE = 2'd0;
    localparam logic [1:0] REG_INT_BASE   = 2'd1;
    localparam logic [1:0] REG_MAX_WIDTH  = 2'd2;

    localparam logic [4:0] BASE_AUTO  = 5'd0;
    localparam logic [4:0] BASE_OCT   = 5'd8;
    localparam logic [4:0] BASE_DEC   = 5'd10;
    localparam logic [4:0] BASE_HEX   = 5'd16;

    localparam logic [0:7][7:0] INF_WORD = "infinity";
    localparam logic [0:2][7:0] NAN_WORD = "nan";

    typedef struct packed {
        logic       float_mode;
        logic [4:0] int_base;
        logic [8:0] max_width;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [8:0] length;
        logic [4:0] wbase;
        logic [4:0] flags;
        logic [3:0] widx;
        logic       closed;
    } state_t;

    localparam state_t CLEAR_STATE = '{
        phase:  PH_START,
        length: 9'd0,
        wbase:  5'd0,
        flags:  5'd0,
        widx:   4'd0,
        closed: 1'b0
    };

    typedef struct packed {
        logic       take;
        logic [8:0] length;
        logic       complete;
        logic       ended;
    } res_t;

endpackage

// ----- design/nptr_cfg.sv -----
// ----------------------------------------------------------------------------
// nptr_cfg
// Configuration register file: float mode, integer base, width limit.
// ----------------------------------------------------------------------------
module nptr_cfg
    import nptr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [8:0] wr_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.float_mode <= 1'b0;
            cfg_reg.int_base   <= BASE_DEC;
            cfg_reg.max_width  <= 9'd0;
        end else if (wr_en) begin
            case (wr_index)
                REG_FLOAT_MODE: cfg_reg.float_mode <= wr_data[0];
                REG_INT_BASE:   cfg_reg.int_base   <= wr_data[4:0];
                REG_MAX_WIDTH:  cfg_reg.max_width  <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/nptr_step.sv -----
// ----------------------------------------------------------------------------
// nptr_step
// One grammar step: next recognizer state and the result for one character.
// ----------------------------------------------------------------------------
module nptr_step
    import nptr_pkg::*;
(
    input  state_t     st,
    input  cfg_t       cfg,
    input  logic [8:0] limit,
    input  logic [7:0] ch,
    input  logic       first,
    output state_t     st_next,
    output res_t       res
);

    typedef struct packed {
        logic       ok;
        logic [4:0] flags;
    } fstep_t;

    typedef struct packed {
        logic       ok;
        phase_t     phase;
        logic [4:0] wbase;
    } istep_t;

    typedef struct packed {
        logic       ok;
        phase_t     phase;
        logic [4:0] flags;
        logic [3:0] widx;
    } ffirst_t;

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        logic [7:0] l;
        l = lower(c);
        return l >= "a" && l <= "z";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        logic [7:0] l;
        l = lower(c);
        return is_dec(c) || (l >= "a" && l <= "f");
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic logic [6:0] digit_value(input logic [7:0] c);
        logic [7:0] l;
        l = lower(c);
        if (is_dec(l)) return 7'(l - "0");
        if (l >= "a" && l <= "z") return 7'(l - "a" + 8'd10);
        return 7'd99;
    endfunction

    function automatic fstep_t dec_step(input logic [7:0] c, input logic [4:0] v);
        fstep_t r;
        r.ok    = 1'b1;
        r.flags = v;
        if (is_dec(c)) begin
            if (v[FL_EXP]) r.flags[FL_EDIG] = 1'b1;
            else r.flags[FL_DIG] = 1'b1;
        end else if (c == "." && !v[FL_DOT] && !v[FL_EXP]) begin
            r.flags[FL_DOT] = 1'b1;
        end else if (lower(c) == "e" && !v[FL_EXP] && v[FL_DIG]) begin
            r.flags[FL_EXP] = 1'b1;
        end else if (is_sign(c) && v[FL_EXP] && !v[FL_ESGN] && !v[FL_EDIG]) begin
            r.flags[FL_ESGN] = 1'b1;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic fstep_t hex_step(input logic [7:0] c, input logic [4:0] v);
        fstep_t r;
        r.ok    = 1'b1;
        r.flags = v;
        if (!v[FL_EXP] && is_hex(c)) begin
            r.flags[FL_DIG] = 1'b1;
        end else if (!v[FL_EXP] && c == "." && !v[FL_DOT]) begin
            r.flags[FL_DOT] = 1'b1;
        end else if (!v[FL_EXP] && lower(c) == "p" && v[FL_DIG]) begin
            r.flags[FL_EXP] = 1'b1;
        end else if (v[FL_EXP] && is_sign(c) && !v[FL_ESGN] && !v[FL_EDIG]) begin
            r.flags[FL_ESGN] = 1'b1;
        end else if (v[FL_EXP] && is_dec(c)) begin
            r.flags[FL_EDIG] = 1'b1;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic istep_t int_first(input logic [7:0] c, input logic [4:0] wb);
        istep_t     r;
        logic [4:0] b;
        r.ok    = 1'b0;
        r.phase = PH_START;
        r.wbase = wb;
        b       = (wb == BASE_AUTO) ? BASE_DEC : wb;
        if ((wb == BASE_AUTO || wb == BASE_HEX) && c == "0") begin
            r.ok    = 1'b1;
            r.phase = PH_IZERO;
        end else if (digit_value(c) < {2'b00, b}) begin
            r.ok    = 1'b1;
            r.phase = PH_IDIG;
            r.wbase = b;
        end
        return r;
    endfunction

    function automatic ffirst_t float_first(input logic [7:0] c, input logic [4:0] v,
                                            input logic [3:0] wi);
        ffirst_t r;
        fstep_t  d;
        r.ok    = 1'b1;
        r.phase = PH_START;
        r.flags = v;
        r.widx  = wi;
        d       = dec_step(c, v);
        if (lower(c) == "i") begin
            r.phase = PH_FINF;
            r.widx  = 4'd1;
        end else if (lower(c) == "n") begin
            r.phase = PH_FNAN;
            r.widx  = 4'd1;
        end else if (c == "0") begin
            r.phase = PH_FZERO;
            r.flags = 5'd1 << FL_DIG;
        end else if (d.ok) begin
            r.phase = PH_FDEC;
            r.flags = d.flags;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    state_t     cur;
    state_t     nxt;
    logic       ok;
    logic       full_num;
    logic [7:0] lc;
    logic [4:0] base8;
    istep_t     is_r;
    ffirst_t    ff_r;
    fstep_t     dec_r;
    fstep_t     hex_r;

    always_comb begin
        cur   = first ? CLEAR_STATE : st;
        nxt   = cur;
        ok    = 1'b0;
        lc    = lower(ch);
        base8 = (cur.wbase == BASE_AUTO) ? BASE_OCT : cur.wbase;
        is_r  = int_first(ch, (cur.phase == PH_START) ? cfg.int_base : cur.wbase);
        ff_r  = float_first(ch, cur.flags, cur.widx);
        dec_r = dec_step(ch, cur.flags);
        hex_r = hex_step(ch, cur.flags);

        case (cur.phase)
            PH_START: begin
                if (cfg.float_mode) begin
                    if (is_sign(ch)) begin
                        ok        = 1'b1;
                        nxt.phase = PH_FSIGN;
                    end else if (ff_r.ok) begin
                        ok        = 1'b1;
                        nxt.phase = ff_r.phase;
                        nxt.flags = ff_r.flags;
                        nxt.widx  = ff_r.widx;
                    end
                end else begin
                    if (is_sign(ch)) begin
                        ok        = 1'b1;
                        nxt.phase = PH_ISIGN;
                        nxt.wbase = cfg.int_base;
                    end else if (is_r.ok) begin
                        ok        = 1'b1;
                        nxt.phase = is_r.phase;
                        nxt.wbase = is_r.wbase;
                    end
                end
            end
            PH_ISIGN: begin
                if (is_r.ok) begin
                    ok        = 1'b1;
                    nxt.phase = is_r.phase;
                    nxt.wbase = is_r.wbase;
                end
            end
            PH_IZERO: begin
                if (lc == "x") begin
                    ok        = 1'b1;
                    nxt.phase = PH_IPFX;
                    nxt.wbase = BASE_HEX;
                end else if (digit_value(ch) < {2'b00, base8}) begin
                    ok        = 1'b1;
                    nxt.phase = PH_IDIG;
                    nxt.wbase = base8;
                end
            end
            PH_IPFX, PH_IDIG: begin
                if (digit_value(ch) < {2'b00, cur.wbase}) begin
                    ok        = 1'b1;
                    nxt.phase = PH_IDIG;
                end
            end
            PH_FSIGN: begin
                if (ff_r.ok) begin
                    ok        = 1'b1;
                    nxt.phase = ff_r.phase;
                    nxt.flags = ff_r.flags;
                    nxt.widx  = ff_r.widx;
                end
            end
            PH_FZERO: begin
                if (lc == "x") begin
                    ok        = 1'b1;
                    nxt.phase = PH_FHEX;
                    nxt.flags = 5'd0;
                end else if (dec_r.ok) begin
                    ok        = 1'b1;
                    nxt.phase = PH_FDEC;
                    nxt.flags = dec_r.flags;
                end
            end
            PH_FDEC: begin
                ok        = dec_r.ok;
                nxt.flags = dec_r.flags;
            end
            PH_FHEX: begin
                ok        = hex_r.ok;
                nxt.flags = hex_r.flags;
            end
            PH_FINF: begin
                if (cur.widx < 4'd8 && lc == INF_WORD[cur.widx[2:0]]) begin
                    ok       = 1'b1;
                    nxt.widx = cur.widx + 4'd1;
                end
            end
            PH_FNAN: begin
                if (cur.widx < 4'd3) begin
                    if (lc == NAN_WORD[cur.widx[1:0]]) begin
                        ok       = 1'b1;
                        nxt.widx = cur.widx + 4'd1;
                    end
                end else if (ch == "(") begin
                    ok        = 1'b1;
                    nxt.phase = PH_FNSEQ;
                end
            end
            PH_FNSEQ: begin
                if (ch == ")") begin
                    ok        = 1'b1;
                    nxt.phase = PH_FNEND;
                end else if (is_dec(ch) || is_alpha(ch) || ch == "_") begin
                    ok = 1'b1;
                end
            end
            default: ;
        endcase

        st_next  = cur;
        res.take = 1'b0;
        if (!cur.closed) begin
            if (cur.length >= limit) begin
                st_next.closed = 1'b1;
            end else if (ok) begin
                st_next        = nxt;
                st_next.length = cur.length + 9'd1;
                st_next.closed = (cur.length + 9'd1) >= limit;
                res.take       = 1'b1;
            end else begin
                st_next.closed = 1'b1;
            end
        end

        case (st_next.phase)
            PH_IZERO, PH_IDIG, PH_FZERO, PH_FNEND: full_num = 1'b1;
            PH_FDEC, PH_FHEX:
                full_num = st_next.flags[FL_DIG] &&
                           (!st_next.flags[FL_EXP] || st_next.flags[FL_EDIG]);
            PH_FINF: full_num = st_next.widx == 4'd3 || st_next.widx == 4'd8;
            PH_FNAN: full_num = st_next.widx == 4'd3;
            default: full_num = 1'b0;
        endcase

        res.length   = st_next.length;
        res.complete = full_num;
        res.ended    = st_next.closed;
    end

endmodule

// ----- design/numeric_token_prefix_recognizer_top.sv -----
// ----------------------------------------------------------------------------
// numeric_token_prefix_recognizer_top
// Character-at-a-time lexer for C integer and floating-point number tokens.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one character per transfer (tdata = ch, tuser = first).
//   first = 1 starts a new token with that character.
//   m_* returns one result per character: take, running length, complete
//   and ended. A rejected character (take = 0) belongs to the next token.
//   cfg_* writes float_mode (0), int_base (1) and max_width (2); write only
//   while no character is in flight.
// Timing:
//   An accepted character is held in an input register; the grammar step
//   runs on it once the output can take a result and loads the result
//   register, which offers it. One character per cycle is sustained while
//   m_tready is high; the recognizer state loop is a single register stage.
//   When m_tready is low, the held result stays and the input register
//   takes one more character only while empty, then s_tready drops.
// Reset:
//   Clears both pipeline registers, starts a fresh token and loads
//   float_mode = 0, int_base = 10, max_width = 0 (limit TOKEN_CAP-1, at most 511).
// ----------------------------------------------------------------------------
module numeric_token_prefix_recognizer_top
    import nptr_pkg::*;
#(
    parameter int TOKEN_CAP = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [0:0]  s_tuser,   // [0] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] take, [9:1] length, [10] complete, [11] ended
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam logic [8:0] LIM_MAX = (TOKEN_CAP - 1 > 511) ? 9'd511 : 9'(TOKEN_CAP - 1);

    cfg_t       cfg;
    state_t     st_reg;
    state_t     st_next;
    res_t       res_next;
    res_t       out_res_reg;
    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       in_first_reg;
    logic       out_valid_reg;
    logic       fire;
    logic [8:0] limit;

    assign cfg_ready = 1'b1;

    nptr_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign limit = (cfg.max_width != 9'd0 && cfg.max_width < LIM_MAX) ? cfg.max_width : LIM_MAX;

    nptr_step u_step (
        .st      (st_reg),
        .cfg     (cfg),
        .limit   (limit),
        .ch      (in_ch_reg),
        .first   (in_first_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= CLEAR_STATE;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg    <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
        if (fire) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_res_reg.ended, out_res_reg.complete,
                       out_res_reg.length, out_res_reg.take};

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.length <= LIM_MAX)
        else $error("token length beyond store limit");

    a_take_incr: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !in_first_reg && res_next.take |=>
            st_reg.length == 9'($past(st_reg.length) + 9'd1))
        else $error("accepted character did not extend token by one");

    a_reject_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !res_next.take |=> st_reg.closed)
        else $error("rejected character left token open");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while both stages full and output stalled");
`endif

endmodule

// ----- tb/numeric_token_prefix_recognizer_top_tb.sv -----
// ----------------------------------------------------------------------------
// numeric_token_prefix_recognizer_top_tb
// Self-checking bench for the character-at-a-time number token lexer.
// A directed table covers the reset behavior, width limits, closed tokens,
// the 0x prefix, nan and inf. Random phases follow under varied settings.
// They drive mostly well-formed integer and float tokens, with some corruption
// and noise. Every result is checked against the table or a local lexer predictor.
// ----------------------------------------------------------------------------
module numeric_token_prefix_recognizer_top_tb;
    import nptr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TOKEN_CAP    = 512;
    localparam int unsigned NUM_PHASES   = 12;
    localparam int unsigned PHASE_ITEMS  = 6;
    localparam int unsigned LONG_RUN     = 512;
    localparam int unsigned STALL_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_FLOAT_MODE;
    logic [8:0]  cfg_data  = '0;

    typedef struct {
        bit         is_cfg;
        cfg_t       cfg;
        logic [7:0] ch;
        logic       lead;
        bit         typed;
        res_t       want;
    } plan_row_t;

    plan_row_t   plan_q[$];
    res_t        verdict_q[$];
    logic [7:0]  tok_q[$];
    cfg_t        cfg_now;
    state_t      lex_st;
    bit          gaps_on     = 1'b0;
    int unsigned err_count   = 0;
    int unsigned rx_count    = 0;
    int unsigned cycle_count = 0;

    numeric_token_prefix_recognizer_top #(
        .TOKEN_CAP(TOKEN_CAP)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // lexer predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit is_dec(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_sign(logic [7:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        logic [7:0] lc;
        lc = to_lower(c);
        return is_dec(c) || (lc >= "a" && lc <= "f");
    endfunction

    function automatic int unsigned digit_val(logic [7:0] c);
        logic [7:0] lc;
        lc = to_lower(c);
        if (is_dec(lc)) return lc - "0";
        if (lc >= "a" && lc <= "z") return lc - "a" + 10;
        return 99;
    endfunction

    function automatic bit dec_step(logic [7:0] c, inout logic [4:0] fl);
        if (is_dec(c)) begin
            if (fl[FL_EXP]) fl[FL_EDIG] = 1'b1;
            else fl[FL_DIG] = 1'b1;
            return 1'b1;
        end
        if (c == "." && !fl[FL_DOT] && !fl[FL_EXP]) begin
            fl[FL_DOT] = 1'b1;
            return 1'b1;
        end
        if (to_lower(c) == "e" && !fl[FL_EXP] && fl[FL_DIG]) begin
            fl[FL_EXP] = 1'b1;
            return 1'b1;
        end
        if (is_sign(c) && fl[FL_EXP] && !fl[FL_ESGN] && !fl[FL_EDIG]) begin
            fl[FL_ESGN] = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit hex_step(logic [7:0] c, inout logic [4:0] fl);
        bit ex;
        ex = fl[FL_EXP];
        if (!ex && is_hex(c)) begin
            fl[FL_DIG] = 1'b1;
            return 1'b1;
        end
        if (!ex && c == "." && !fl[FL_DOT]) begin
            fl[FL_DOT] = 1'b1;
            return 1'b1;
        end
        if (!ex && to_lower(c) == "p" && fl[FL_DIG]) begin
            fl[FL_EXP] = 1'b1;
            return 1'b1;
        end
        if (ex && is_sign(c) && !fl[FL_ESGN] && !fl[FL_EDIG]) begin
            fl[FL_ESGN] = 1'b1;
            return 1'b1;
        end
        if (ex && is_dec(c)) begin
            fl[FL_EDIG] = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // first digit after an optional sign in integer mode
    function automatic bit int_lead(logic [7:0] c, inout phase_t ph, inout logic [4:0] wb);
        logic [4:0] b;
        b = wb;
        if ((b == BASE_AUTO || b == BASE_HEX) && c == "0") begin
            ph = PH_IZERO;
            return 1'b1;
        end
        if (b == BASE_AUTO) b = BASE_DEC;
        if (digit_val(c) < b) begin
            ph = PH_IDIG;
            wb = b;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit float_lead(logic [7:0] c, inout phase_t ph,
                                      inout logic [4:0] fl, inout logic [3:0] wi);
        logic [7:0] lc;
        lc = to_lower(c);
        if (lc == "i") begin
            ph = PH_FINF;
            wi = 4'd1;
            return 1'b1;
        end
        if (lc == "n") begin
            ph = PH_FNAN;
            wi = 4'd1;
            return 1'b1;
        end
        if (c == "0") begin
            ph = PH_FZERO;
            fl = '0;
            fl[FL_DIG] = 1'b1;
            return 1'b1;
        end
        if (dec_step(c, fl)) begin
            ph = PH_FDEC;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit grammar_step(logic [7:0] c, inout state_t st);
        phase_t     ph;
        logic [4:0] fl;
        logic [4:0] wb;
        logic [3:0] wi;
        logic [7:0] lc;
        bit         ok;
        ph = st.phase;
        fl = st.flags;
        wb = st.wbase;
        wi = st.widx;
        lc = to_lower(c);
        ok = 1'b0;
        case (ph)
            PH_START: begin
                if (cfg_now.float_mode) begin
                    if (is_sign(c)) begin
                        ph = PH_FSIGN;
                        ok = 1'b1;
                    end else begin
                        ok = float_lead(c, ph, fl, wi);
                    end
                end else begin
                    wb = cfg_now.int_base;
                    if (is_sign(c)) begin
                        ph = PH_ISIGN;
                        ok = 1'b1;
                    end else begin
                        ok = int_lead(c, ph, wb);
                    end
                end
            end
            PH_ISIGN: ok = int_lead(c, ph, wb);
            PH_IZERO: begin
                if (lc == "x") begin
                    ph = PH_IPFX;
                    wb = BASE_HEX;
                    ok = 1'b1;
                end else begin
                    if (wb == BASE_AUTO) wb = BASE_OCT;
                    if (digit_val(c) < wb) begin
                        ph = PH_IDIG;
                        ok = 1'b1;
                    end
                end
            end
            PH_IPFX, PH_IDIG: begin
                if (digit_val(c) < wb) begin
                    ph = PH_IDIG;
                    ok = 1'b1;
                end
            end
            PH_FSIGN: ok = float_lead(c, ph, fl, wi);
            PH_FZERO: begin
                if (lc == "x") begin
                    ph = PH_FHEX;
                    fl = '0;
                    ok = 1'b1;
                end else if (dec_step(c, fl)) begin
                    ph = PH_FDEC;
                    ok = 1'b1;
                end
            end
            PH_FDEC: ok = dec_step(c, fl);
            PH_FHEX: ok = hex_step(c, fl);
            PH_FINF: begin
                if (wi < 4'd8 && lc == INF_WORD[wi[2:0]]) begin
                    wi++;
                    ok = 1'b1;
                end
            end
            PH_FNAN: begin
                if (wi < 4'd3) begin
                    if (lc == NAN_WORD[wi[1:0]]) begin
                        wi++;
                        ok = 1'b1;
                    end
                end else if (c == "(") begin
                    ph = PH_FNSEQ;
                    ok = 1'b1;
                end
            end
            PH_FNSEQ: begin
                if (c == ")") begin
                    ph = PH_FNEND;
                    ok = 1'b1;
                end else if (is_dec(c) || (lc >= "a" && lc <= "z") || c == "_") begin
                    ok = 1'b1;
                end
            end
            default: ;
        endcase
        if (ok) begin
            st.phase = ph;
            st.flags = fl;
            st.wbase = wb;
            st.widx  = wi;
        end
        return ok;
    endfunction

    function automatic logic token_complete(state_t st);
        case (st.phase)
            PH_IZERO, PH_IDIG, PH_FZERO, PH_FNEND: return 1'b1;
            PH_FDEC, PH_FHEX:
                return st.flags[FL_DIG] && (!st.flags[FL_EXP] || st.flags[FL_EDIG]);
            PH_FINF: return st.widx == 4'd3 || st.widx == 4'd8;
            PH_FNAN: return st.widx == 4'd3;
            default: return 1'b0;
        endcase
    endfunction

    function automatic res_t lex_char(logic [7:0] c, logic lead);
        res_t        r;
        int unsigned lim;
        if (lead) lex_st = CLEAR_STATE;
        lim = (cfg_now.max_width > 0 && cfg_now.max_width < TOKEN_CAP - 1)
              ? cfg_now.max_width : TOKEN_CAP - 1;
        if (lim > 511) lim = 511;
        r.take = 1'b0;
        if (!lex_st.closed) begin
            if (lex_st.length >= lim) begin
                lex_st.closed = 1'b1;
            end else if (grammar_step(c, lex_st)) begin
                lex_st.length++;
                r.take = 1'b1;
                if (lex_st.length >= lim) lex_st.closed = 1'b1;
            end else begin
                lex_st.closed = 1'b1;
            end
        end
        r.length   = lex_st.length;
        r.complete = token_complete(lex_st);
        r.ended    = lex_st.closed;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // token generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_case(logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
        return c;
    endfunction

    function automatic logic [7:0] digit_char(int unsigned v);
        logic [7:0] c;
        c = (v < 10) ? 8'("0" + v) : 8'("a" + v - 10);
        return rand_case(c);
    endfunction

    function automatic void push_digits(int unsigned radix, int unsigned lo, int unsigned hi);
        repeat ($urandom_range(lo, hi)) tok_q.push_back(digit_char($urandom_range(0, radix - 1)));
    endfunction

    function automatic void maybe_sign();
        if ($urandom_range(0, 2) == 0) tok_q.push_back($urandom_range(0, 1) ? "+" : "-");
    endfunction

    function automatic void build_int_token();
        logic [4:0] b;
        b = cfg_now.int_base;
        maybe_sign();
        if (b == BASE_AUTO) begin
            case ($urandom_range(0, 2))
                0: begin
                    tok_q.push_back("0");
                    tok_q.push_back(rand_case("x"));
                    push_digits(16, 1, 4);
                end
                1: begin
                    tok_q.push_back("0");
                    push_digits(8, 0, 3);
                end
                default: begin
                    tok_q.push_back(digit_char($urandom_range(1, 9)));
                    push_digits(10, 0, 3);
                end
            endcase
        end else begin
            if (b == BASE_HEX && $urandom_range(0, 1) == 1) begin
                tok_q.push_back("0");
                tok_q.push_back(rand_case("x"));
            end
            push_digits((b > 1) ? b : 2, 1, 5);
        end
    endfunction

    function automatic void build_float_token();
        int unsigned n;
        maybe_sign();
        case ($urandom_range(0, 3))
            0: begin
                if ($urandom_range(0, 1) == 1) tok_q.push_back("0");
                push_digits(10, 0, 3);
                if ($urandom_range(0, 1) == 1) tok_q.push_back(".");
                push_digits(10, 0, 3);
                if ($urandom_range(0, 1) == 1) begin
                    tok_q.push_back(rand_case("e"));
                    maybe_sign();
                    push_digits(10, 0, 2);
                end
            end
            1: begin
                tok_q.push_back("0");
                tok_q.push_back(rand_case("x"));
                push_digits(16, 0, 3);
                if ($urandom_range(0, 1) == 1) begin
                    tok_q.push_back(".");
                    push_digits(16, 0, 2);
                end
                if ($urandom_range(0, 1) == 1) begin
                    tok_q.push_back(rand_case("p"));
                    maybe_sign();
                    push_digits(10, 0, 2);
                end
            end
            2: begin
                if ($urandom_range(0, 2) == 0) n = $urandom_range(1, 8);
                else n = $urandom_range(0, 1) ? 3 : 8;
                for (int j = 0; j < n; j++) tok_q.push_back(rand_case(INF_WORD[j]));
            end
            default: begin
                for (int j = 0; j < 3; j++) tok_q.push_back(rand_case(NAN_WORD[j]));
                if ($urandom_range(0, 1) == 1) begin
                    tok_q.push_back("(");
                    repeat ($urandom_range(0, 3)) begin
                        n = $urandom_range(0, 36);
                        tok_q.push_back((n < 36) ? digit_char(n) : "_");
                    end
                    if ($urandom_range(0, 4) != 0) tok_q.push_back(")");
                end
            end
        endcase
    endfunction

    function automatic void build_token();
        tok_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) tok_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (cfg_now.float_mode) build_float_token();
        else build_int_token();
        if (tok_q.size() != 0 && $urandom_range(0, 6) == 0)
            tok_q[$urandom_range(0, tok_q.size() - 1)] = 8'($urandom_range(0, 255));
        tok_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    function automatic int unsigned pause_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_char(input logic [7:0] c, input logic lead,
                             input bit typed, input res_t want);
        res_t guess;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= lead;
        do @(posedge aclk); while (!s_tready);
        guess = lex_char(c, lead);
        verdict_q.push_back(typed ? want : guess);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat (pause_len()) @(negedge aclk);
        end
    endtask

    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [8:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FLOAT_MODE: cfg_now.float_mode = d[0];
            REG_INT_BASE:   cfg_now.int_base   = d[4:0];
            REG_MAX_WIDTH:  cfg_now.max_width  = d;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_config(input cfg_t c);
        drain_verdicts();
        cfg_write(REG_FLOAT_MODE, 9'(c.float_mode));
        cfg_write(REG_INT_BASE, 9'(c.int_base));
        cfg_write(REG_MAX_WIDTH, c.max_width);
        cfg_valid <= 1'b0;
    endtask

    function automatic void add_char(logic [7:0] c, logic lead);
        plan_row_t row;
        row = '{default: '0};
        row.ch   = c;
        row.lead = lead;
        plan_q.push_back(row);
    endfunction

    function automatic void add_checked(logic [7:0] c, logic lead, logic tk,
                                        logic [8:0] len, logic cm, logic en);
        plan_row_t row;
        row = '{default: '0};
        row.ch    = c;
        row.lead  = lead;
        row.typed = 1'b1;
        row.want  = '{take: tk, length: len, complete: cm, ended: en};
        plan_q.push_back(row);
    endfunction

    function automatic void add_cfg(logic fm, logic [4:0] b, logic [8:0] w);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg    = '{float_mode: fm, int_base: b, max_width: w};
        plan_q.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("%s", msg);
    endtask

    always @(posedge aclk) begin : result_check
        res_t got;
        res_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.take     = m_tdata[0];
            got.length   = m_tdata[9:1];
            got.complete = m_tdata[10];
            got.ended    = m_tdata[11];
            if (verdict_q.size() == 0) begin
                note_error($sformatf("result %0d arrived with nothing expected: %h",
                                     rx_count, m_tdata));
            end else begin
                want = verdict_q.pop_front();
                if (got.take !== want.take || got.length !== want.length ||
                    got.complete !== want.complete || got.ended !== want.ended)
                    note_error($sformatf({"result %0d mismatch (exp/act): take %b/%b ",
                                          "length %0d/%0d complete %b/%b ended %b/%b"},
                                         rx_count, want.take, got.take, want.length,
                                         got.length, want.complete, got.complete,
                                         want.ended, got.ended));
            end
            rx_count++;
        end
    end

    // receiver: random back-pressure plus one long hold-off
    initial begin : result_sink
        int unsigned hold_left;
        bit          held_once;
        bit          busy;
        hold_left = 0;
        held_once = 1'b0;
        busy      = 1'b1;
        forever begin
            @(negedge aclk);
            if (!held_once && rx_count >= 200) begin
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
            end
            if ($urandom_range(0, 99) == 0) busy = ($urandom_range(0, 3) != 0);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (busy && $urandom_range(0, 3) == 0) begin
                hold_left = pause_len() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        cfg_t        rc;
        int unsigned sent;
        logic        lead;

        cfg_now = '{float_mode: 1'b0, int_base: BASE_DEC, max_width: 9'd0};
        lex_st  = CLEAR_STATE;

        // reset settings: integer, base 10; first step after reset opens a token
        add_checked("7", 1'b0, 1'b1, 9'd1, 1'b1, 1'b0);
        add_checked("a", 1'b0, 1'b0, 9'd1, 1'b1, 1'b1);
        add_checked("x", 1'b0, 1'b0, 9'd1, 1'b1, 1'b1);
        add_checked("-", 1'b1, 1'b1, 9'd1, 1'b0, 1'b0);
        add_checked("9", 1'b0, 1'b1, 9'd2, 1'b1, 1'b0);
        add_checked(8'hFF, 1'b1, 1'b0, 9'd0, 1'b0, 1'b1);
        add_checked(8'h00, 1'b1, 1'b0, 9'd0, 1'b0, 1'b1);
        // base detection through the 0x prefix
        add_cfg(1'b0, BASE_AUTO, 9'd0);
        add_char("0", 1'b1);
        add_char("X", 1'b0);
        add_char("1", 1'b0);
        add_char("f", 1'b0);
        add_char("g", 1'b0);
        // width limit closes the token inside the exponent
        add_cfg(1'b1, BASE_AUTO, 9'd3);
        add_char("1", 1'b1);
        add_char("e", 1'b0);
        add_checked("+", 1'b0, 1'b1, 9'd3, 1'b0, 1'b1);
        add_checked("5", 1'b0, 1'b0, 9'd3, 1'b0, 1'b1);
        // nan with a sequence, then inf
        add_cfg(1'b1, BASE_AUTO, 9'd0);
        add_char("N", 1'b1);
        add_char("a", 1'b0);
        add_char("n", 1'b0);
        add_char("(", 1'b0);
        add_char("_", 1'b0);
        add_char(")", 1'b0);
        add_checked("I", 1'b1, 1'b1, 9'd1, 1'b0, 1'b0);
        add_char("n", 1'b0);
        add_checked("f", 1'b0, 1'b1, 9'd3, 1'b1, 1'b0);

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan_q[i]) begin
            gaps_on = ($urandom_range(0, 1) == 1);
            if (plan_q[i].is_cfg) apply_config(plan_q[i].cfg);
            else send_char(plan_q[i].ch, plan_q[i].lead, plan_q[i].typed, plan_q[i].want);
        end

        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: rc = '{float_mode: 1'b0, int_base: BASE_AUTO, max_width: 9'd0};
                1: rc = '{float_mode: 1'b1, int_base: BASE_DEC,  max_width: 9'd511};
                2: rc = '{float_mode: 1'b0, int_base: BASE_HEX,  max_width: 9'd1};
                3: rc = '{float_mode: 1'b0, int_base: 5'd1,      max_width: 9'd510};
                4: rc = '{float_mode: 1'b1, int_base: BASE_OCT,  max_width: 9'd2};
                default: begin
                    rc.float_mode = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 5))
                        0: rc.int_base = BASE_AUTO;
                        1: rc.int_base = BASE_OCT;
                        2: rc.int_base = BASE_DEC;
                        3: rc.int_base = BASE_HEX;
                        default: rc.int_base = 5'($urandom_range(1, 16));
                    endcase
                    case ($urandom_range(0, 3))
                        0: rc.max_width = 9'd0;
                        1: rc.max_width = 9'($urandom_range(1, 8));
                        2: rc.max_width = 9'($urandom_range(9, 40));
                        default: rc.max_width = 9'd511;
                    endcase
                end
            endcase
            apply_config(rc);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_token();
                gaps_on = ($urandom_range(0, 3) != 0);
                foreach (tok_q[i]) begin
                    if (i == 0) lead = ($urandom_range(0, 4) != 0);
                    else lead = ($urandom_range(0, 39) == 0);
                    send_char(tok_q[i], lead, 1'b0, '0);
                    sent++;
                end
            end
        end

        // one token long enough to hit the token store limit
        apply_config('{float_mode: 1'b0, int_base: BASE_DEC, max_width: 9'd0});
        gaps_on = 1'b0;
        send_char("1", 1'b1, 1'b0, '0);
        repeat (LONG_RUN) send_char(digit_char($urandom_range(0, 9)), 1'b0, 1'b0, '0);

        drain_verdicts();
        repeat (20) @(posedge aclk);
        if (err_count == 0 && verdict_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
